[hw/rtl/fbrop_pkg.sv]
// ----------------------------------------------------------------------------
// fbrop_pkg
// shared constants for the rectangle outline plotter: screen geometry,
// request codes and draw mode codes
// ----------------------------------------------------------------------------
package fbrop_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  typedef logic [1:0] req_t;
  typedef logic [1:0] mode_t;

  localparam req_t REQ_PLOT  = 2'd0;
  localparam req_t REQ_RECT  = 2'd1;
  localparam req_t REQ_CRECT = 2'd2;
  localparam req_t REQ_READ  = 2'd3;

  localparam mode_t MODE_SET    = 2'd0;
  localparam mode_t MODE_CLEAR  = 2'd1;
  localparam mode_t MODE_TOGGLE = 2'd2;
  localparam mode_t MODE_KEEP   = 2'd3;

endpackage

[hw/rtl/framebuffer_rect_outline_plotter.sv]
// ----------------------------------------------------------------------------
// framebuffer_rect_outline_plotter
// page organized monochrome framebuffer with pixel plot, corner and centered
// rectangle outlines and pixel read-back
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | req_type, pos_x, pos_y, rect_width, rect_height
//  out     | output    | out_valid / out_stall| pixel_value, in_range
//  cfg     | input     | cfg_wr_en            | cfg_wr_data (draw mode)
//
//  one transaction at a time; a rectangle plots the top and bottom pixel of every
//  column, then the left and right pixel of every side row, one pixel
//  read-modify-write per cycle through a frame store with one read and one
//  write port and write-to-read forwarding
//  after reset a clearing pass over all PAGES*SCREEN_WIDTH bytes (1024 by default)
//  zeroes the store while in_stall is high; cfg writes are taken at any time
//  the result sits in an output register; in_stall drops once it is loaded
// ----------------------------------------------------------------------------
module framebuffer_rect_outline_plotter #(
  parameter int SCREEN_WIDTH  = fbrop_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = fbrop_pkg::SCREEN_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_pos_x,
  input  logic [7:0] in_pos_y,
  input  logic [7:0] in_rect_width,
  input  logic [7:0] in_rect_height,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_pixel_value,
  output logic       out_in_range
);

  localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int DEPTH = PAGES * SCREEN_WIDTH;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PIX   = 3'd2;
  localparam logic [2:0] ST_TOP   = 3'd3;
  localparam logic [2:0] ST_SIDE  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]       st_r, st_nxt;
  logic [IDX_W-1:0] clr_cnt_r;
  fbrop_pkg::mode_t draw_mode_r;
  fbrop_pkg::req_t  req_r;
  logic [7:0]       a_r, b_r, c_r, d_r;
  logic [7:0]       i_r, i_nxt;
  logic             sub_r, sub_nxt;

  logic [7:0]       frame_store_r [DEPTH];
  logic [7:0]       rdata_r;

  logic             p_vld_r, p_rd_r;
  logic [IDX_W-1:0] p_idx_r;
  logic [2:0]       p_bit_r;
  logic             fw_vld_r;
  logic [IDX_W-1:0] fw_idx_r;
  logic [7:0]       fw_data_r;

  logic             res_pix_r, res_inr_r;
  logic             out_valid_r, out_pixel_value_r, out_in_range_r;

  logic             emit;
  logic [7:0]       px, py, mx, my;
  logic             loc_ok;
  logic [IDX_W-1:0] loc_idx;
  logic [7:0]       acc_a, acc_b, acc_c, acc_d;
  logic [7:0]       cur, mask, wdata;
  logic             wr_pix;
  logic             in_acc;

  assign in_acc   = in_valid && (st_r == ST_IDLE);
  assign in_stall = (st_r != ST_IDLE);

  // rectangle bounds
  always_comb begin
    acc_a = in_pos_x;
    acc_b = in_pos_y;
    acc_c = in_pos_x + in_rect_width;
    acc_d = in_pos_y + in_rect_height;
    if (in_req_type == fbrop_pkg::REQ_CRECT) begin
      acc_a = in_pos_x - {1'b0, in_rect_width[7:1]};
      acc_b = in_pos_y - {1'b0, in_rect_height[7:1]};
      acc_c = in_pos_x + {1'b0, in_rect_width[7:1]};
      acc_d = in_pos_y + {1'b0, in_rect_height[7:1]};
    end
  end

  // pixel sequencer
  always_comb begin
    st_nxt  = st_r;
    i_nxt   = i_r;
    sub_nxt = sub_r;
    emit    = 1'b0;
    px      = a_r;
    py      = b_r;
    unique case (st_r)
      ST_CLEAR: begin
        if (clr_cnt_r == IDX_W'(DEPTH - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_type == fbrop_pkg::REQ_PLOT || in_req_type == fbrop_pkg::REQ_READ) begin
            st_nxt = ST_PIX;
          end else begin
            st_nxt  = ST_TOP;
            i_nxt   = acc_a;
            sub_nxt = 1'b0;
          end
        end
      end
      ST_PIX: begin
        emit   = 1'b1;
        st_nxt = ST_DRAIN;
      end
      ST_TOP: begin
        px = i_r;
        py = sub_r ? (d_r - 8'd1) : b_r;
        if (i_r < c_r) begin
          emit    = 1'b1;
          sub_nxt = ~sub_r;
          if (sub_r) i_nxt = i_r + 8'd1;
        end else begin
          st_nxt  = ST_SIDE;
          i_nxt   = b_r + 8'd1;
          sub_nxt = 1'b0;
        end
      end
      ST_SIDE: begin
        px = sub_r ? (c_r - 8'd1) : a_r;
        py = i_r;
        if (({1'b0, i_r} + 9'd1) < {1'b0, d_r}) begin
          emit    = 1'b1;
          sub_nxt = ~sub_r;
          if (sub_r) i_nxt = i_r + 8'd1;
        end else begin
          st_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: st_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || !out_stall) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // mirror and locate
  always_comb begin
    mx      = 8'(SCREEN_WIDTH - 1) - px;
    my      = 8'(SCREEN_HEIGHT - 1) - py;
    loc_ok  = ({1'b0, mx} < 9'(SCREEN_WIDTH)) && ({1'b0, my} < 9'(SCREEN_HEIGHT));
    loc_idx = IDX_W'(int'(my[7:3]) * SCREEN_WIDTH + int'(mx));
  end

  // read-modify-write stage with forwarding from the previous write
  always_comb begin
    cur  = (fw_vld_r && fw_idx_r == p_idx_r) ? fw_data_r : rdata_r;
    mask = 8'd1 << p_bit_r;
    case (draw_mode_r)
      fbrop_pkg::MODE_SET:    wdata = cur | mask;
      fbrop_pkg::MODE_CLEAR:  wdata = cur & ~mask;
      fbrop_pkg::MODE_TOGGLE: wdata = cur ^ mask;
      default:                wdata = cur;
    endcase
    wr_pix = p_vld_r && !p_rd_r && (draw_mode_r != fbrop_pkg::MODE_KEEP);
  end

  always_ff @(posedge clk) begin
    rdata_r <= frame_store_r[loc_idx];
    if (st_r == ST_CLEAR) begin
      frame_store_r[clr_cnt_r] <= 8'd0;
    end else if (wr_pix) begin
      frame_store_r[p_idx_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_cnt_r   <= '0;
      draw_mode_r <= fbrop_pkg::MODE_SET;
      p_vld_r     <= 1'b0;
      fw_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      p_vld_r  <= emit && loc_ok;
      fw_vld_r <= wr_pix;
      if (st_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      if (cfg_wr_en) draw_mode_r <= cfg_wr_data;
      if (st_r == ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    sub_r     <= sub_nxt;
    p_idx_r   <= loc_idx;
    p_bit_r   <= my[2:0];
    p_rd_r    <= (req_r == fbrop_pkg::REQ_READ);
    fw_idx_r  <= p_idx_r;
    fw_data_r <= wdata;
    if (in_acc) begin
      req_r     <= in_req_type;
      a_r       <= acc_a;
      b_r       <= acc_b;
      c_r       <= acc_c;
      d_r       <= acc_d;
      res_pix_r <= 1'b0;
      res_inr_r <= 1'b0;
    end
    if (st_r == ST_PIX) res_inr_r <= loc_ok;
    if (p_vld_r && p_rd_r) res_pix_r <= cur[p_bit_r];
    if (st_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_pixel_value_r <= res_pix_r;
      out_in_range_r    <= res_inr_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pixel_value_r;
  assign out_in_range    = out_in_range_r;

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !p_vld_r)
    else $error("pixel still in flight while accepting");

  a_pipe_state: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> (st_r == ST_TOP || st_r == ST_SIDE || st_r == ST_DRAIN))
    else $error("pixel stage active outside drawing");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == ST_DONE))
    else $error("result raised without finishing a transaction");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// testbench for framebuffer_rect_outline_plotter: directed edge cases, then
// random traffic with gaps and stalls, checked in order against a bench copy
// of the frame store
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 20;
  localparam int PAGE_BYTES  = ((fbrop_pkg::SCREEN_HEIGHT + 7) / 8) *
                               fbrop_pkg::SCREEN_WIDTH;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 390;
  localparam int MODE_SPAN = 65;

  typedef struct packed {
    logic pixel_value;
    logic in_range;
  } pixel_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = fbrop_pkg::MODE_SET;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_req_type = fbrop_pkg::REQ_PLOT;
  logic [7:0] in_pos_x = 8'd0;
  logic [7:0] in_pos_y = 8'd0;
  logic [7:0] in_rect_width = 8'd0;
  logic [7:0] in_rect_height = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_pixel_value;
  logic       out_in_range;

  logic [7:0]       frame_model [PAGE_BYTES];
  fbrop_pkg::mode_t draw_mode_model = fbrop_pkg::MODE_SET;
  pixel_result_t    expected_pixels [$];
  int               mismatch_count = 0;
  int               snd_idle_pct = 0;
  int               rcv_idle_pct = 0;
  int               mode_step = 0;
  int               cycle_count;
  fbrop_pkg::mode_t mode_cycle [4] = '{fbrop_pkg::MODE_SET, fbrop_pkg::MODE_TOGGLE,
                                       fbrop_pkg::MODE_CLEAR, fbrop_pkg::MODE_KEEP};

  framebuffer_rect_outline_plotter DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_value(out_pixel_value),
    .out_in_range   (out_in_range)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // mirrored point to store byte and bit
  function automatic bit find_pixel(input logic [7:0] x, input logic [7:0] y,
                                    output int idx, output int bit_pos);
    logic [7:0] mx;
    logic [7:0] my;
    mx = 8'(fbrop_pkg::SCREEN_WIDTH - 1) - x;
    my = 8'(fbrop_pkg::SCREEN_HEIGHT - 1) - y;
    idx = 0;
    bit_pos = 0;
    if (mx >= fbrop_pkg::SCREEN_WIDTH || my >= fbrop_pkg::SCREEN_HEIGHT) return 1'b0;
    idx = int'(my >> 3) * fbrop_pkg::SCREEN_WIDTH + int'(mx);
    bit_pos = int'(my[2:0]);
    return (idx < PAGE_BYTES);
  endfunction

  function automatic void paint_pixel(input logic [7:0] x, input logic [7:0] y);
    int idx;
    int bit_pos;
    logic [7:0] mask;
    if (!find_pixel(x, y, idx, bit_pos)) return;
    mask = 8'd1 << bit_pos;
    case (draw_mode_model)
      fbrop_pkg::MODE_SET:    frame_model[idx] = frame_model[idx] | mask;
      fbrop_pkg::MODE_CLEAR:  frame_model[idx] = frame_model[idx] & ~mask;
      fbrop_pkg::MODE_TOGGLE: frame_model[idx] = frame_model[idx] ^ mask;
      default: ;
    endcase
  endfunction

  // a = left, b = top, c = right end, d = bottom end, both ends exclusive
  function automatic void trace_outline(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] d);
    int i;
    logic [7:0] bottom_row;
    logic [7:0] right_col;
    logic [7:0] first_row;
    bottom_row = d - 8'd1;
    right_col = c - 8'd1;
    first_row = b + 8'd1;
    for (i = int'(a); i < int'(c); i++) begin
      paint_pixel(8'(i), b);
      paint_pixel(8'(i), bottom_row);
    end
    for (i = int'(first_row); i < int'(d) - 1; i++) begin
      paint_pixel(a, 8'(i));
      paint_pixel(right_col, 8'(i));
    end
  endfunction

  function automatic pixel_result_t predict_result(input fbrop_pkg::req_t req,
                                                   input logic [7:0] x,
                                                   input logic [7:0] y, input logic [7:0] w,
                                                   input logic [7:0] h);
    pixel_result_t res;
    int idx;
    int bit_pos;
    logic [7:0] half_w;
    logic [7:0] half_h;
    res = '0;
    half_w = w >> 1;
    half_h = h >> 1;
    case (req)
      fbrop_pkg::REQ_PLOT: begin
        res.in_range = find_pixel(x, y, idx, bit_pos);
        paint_pixel(x, y);
      end
      fbrop_pkg::REQ_RECT: trace_outline(x, y, x + w, y + h);
      fbrop_pkg::REQ_CRECT: trace_outline(x - half_w, y - half_h, x + half_w, y + half_h);
      default: begin
        if (find_pixel(x, y, idx, bit_pos)) begin
          res.in_range = 1'b1;
          res.pixel_value = frame_model[idx][bit_pos];
        end
      end
    endcase
    return res;
  endfunction

  task automatic send_request(input fbrop_pkg::req_t req, input logic [7:0] x,
                              input logic [7:0] y,
                              input logic [7:0] w, input logic [7:0] h);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_rect_width  <= w;
    in_rect_height <= h;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_pixels.push_back(predict_result(req, x, y, w, h));
    @(negedge clk);
  endtask

  task automatic set_draw_mode(input fbrop_pkg::mode_t mode);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    draw_mode_model = mode;
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected transaction, pixel_value %0b in_range %0b",
                 $time, out_pixel_value, out_in_range);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel_value !== want.pixel_value) begin
          $display("%0t: pixel_value expected %0b actual %0b",
                   $time, want.pixel_value, out_pixel_value);
          mismatch_count++;
        end
        if (out_in_range !== want.in_range) begin
          $display("%0t: in_range expected %0b actual %0b",
                   $time, want.in_range, out_in_range);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic test_pixel_bounds();
    set_draw_mode(fbrop_pkg::MODE_SET);
    send_request(fbrop_pkg::REQ_PLOT, 8'd0, 8'd0, 8'd255, 8'd255);
    send_request(fbrop_pkg::REQ_PLOT, 8'd127, 8'd63, 8'd0, 8'd0);
    send_request(fbrop_pkg::REQ_PLOT, 8'd128, 8'd5, 8'd0, 8'd0);
    send_request(fbrop_pkg::REQ_PLOT, 8'd5, 8'd64, 8'd0, 8'd0);
    send_request(fbrop_pkg::REQ_PLOT, 8'd255, 8'd255, 8'd0, 8'd0);
    send_request(fbrop_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0);
    send_request(fbrop_pkg::REQ_READ, 8'd127, 8'd63, 8'd0, 8'd0);
    send_request(fbrop_pkg::REQ_READ, 8'd255, 8'd255, 8'd255, 8'd255);
  endtask

  task automatic test_draw_modes();
    set_draw_mode(fbrop_pkg::MODE_CLEAR);
    send_request(fbrop_pkg::REQ_PLOT, 8'd0, 8'd0, 8'd0, 8'd0);
    send_request(fbrop_pkg::REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0);
    set_draw_mode(fbrop_pkg::MODE_TOGGLE);
    send_request(fbrop_pkg::REQ_PLOT, 8'd10, 8'd10, 8'd0, 8'd0);
    send_request(fbrop_pkg::REQ_READ, 8'd10, 8'd10, 8'd0, 8'd0);
    send_request(fbrop_pkg::REQ_PLOT, 8'd10, 8'd10, 8'd0, 8'd0);
    send_request(fbrop_pkg::REQ_READ, 8'd10, 8'd10, 8'd0, 8'd0);
    set_draw_mode(fbrop_pkg::MODE_KEEP);
    send_request(fbrop_pkg::REQ_PLOT, 8'd127, 8'd63, 8'd0, 8'd0);
    send_request(fbrop_pkg::REQ_READ, 8'd127, 8'd63, 8'd0, 8'd0);
  endtask

  task automatic test_corner_rects();
    set_draw_mode(fbrop_pkg::MODE_SET);
    send_request(fbrop_pkg::REQ_RECT, 8'd10, 8'd5, 8'd8, 8'd4);
    send_request(fbrop_pkg::REQ_RECT, 8'd20, 8'd20, 8'd0, 8'd0);
    // right end wraps below the left edge, only the sides remain
    send_request(fbrop_pkg::REQ_RECT, 8'd250, 8'd3, 8'd10, 8'd6);
    // top row at 255, sides wrap to start from row 0
    send_request(fbrop_pkg::REQ_RECT, 8'd2, 8'd255, 8'd5, 8'd7);
    // bottom end wraps to 0, no sides
    send_request(fbrop_pkg::REQ_RECT, 8'd3, 8'd250, 8'd4, 8'd6);
    send_request(fbrop_pkg::REQ_RECT, 8'd0, 8'd0, 8'd255, 8'd255);
    send_request(fbrop_pkg::REQ_READ, 8'd12, 8'd5, 8'd0, 8'd0);
  endtask

  task automatic test_centered_rects();
    set_draw_mode(fbrop_pkg::MODE_TOGGLE);
    send_request(fbrop_pkg::REQ_CRECT, 8'd64, 8'd32, 8'd9, 8'd7);
    send_request(fbrop_pkg::REQ_CRECT, 8'd1, 8'd1, 8'd20, 8'd20);
    send_request(fbrop_pkg::REQ_CRECT, 8'd100, 8'd40, 8'd255, 8'd255);
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
    int n;
    fbrop_pkg::req_t req;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [7:0] h;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % MODE_SPAN == 0) begin
        set_draw_mode(mode_cycle[mode_step % 4]);
        mode_step++;
      end
      req = fbrop_pkg::req_t'($urandom_range(3));
      if ($urandom_range(3) == 0 ||
          (req != fbrop_pkg::REQ_RECT && req != fbrop_pkg::REQ_CRECT &&
           $urandom_range(9) == 0)) begin
        x = 8'($urandom_range(255));
        y = 8'($urandom_range(255));
      end else begin
        x = 8'($urandom_range(fbrop_pkg::SCREEN_WIDTH - 1));
        y = 8'($urandom_range(fbrop_pkg::SCREEN_HEIGHT - 1));
      end
      if (req == fbrop_pkg::REQ_PLOT || req == fbrop_pkg::REQ_READ ||
          $urandom_range(24) == 0) begin
        w = 8'($urandom_range(255));
        h = 8'($urandom_range(255));
      end else begin
        w = 8'($urandom_range(20));
        h = 8'($urandom_range(20));
      end
      send_request(req, x, y, w, h);
    end
  endtask

  initial begin
    foreach (frame_model[i]) frame_model[i] = 8'd0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_pixel_bounds();
    test_draw_modes();
    test_corner_rects();
    test_centered_rects();
    test_random_traffic(29, 70);
    test_random_traffic(70, 29);
    test_random_traffic(0, 0);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
